@@ src/smt_pkg.sv @@
// Shared types and codes for the sorted multiset table.
// Used by the controller, the datapath and the top level; no dependencies.
package smt_pkg;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;
  localparam logic [1:0] STS_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] item_id;
    logic [6:0]  amount;
    logic [5:0]  index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic [6:0]  changed;
    logic [15:0] read_value;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_SCAN_END,
    OP_UP_RD,
    OP_UP_WR,
    OP_FILL,
    OP_DN_RD,
    OP_DN_WR,
    OP_READ_RD,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    logic [1:0] req;
    logic       full;
    logic       amt_zero;
    logic       idx_ok;
    logic       at_end;
    logic       go;
    logic       found;
    logic       up_done;
    logic       fill_done;
    logic       dn_done;
  } dp_stat_t;

endpackage

@@ src/smt_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module smt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/smt_dp.sv @@
// Datapath of the sorted multiset table: request, count, pointers, result and table RAM.
// Depends on smt_pkg and smt_ram; driven by smt_ctrl operation codes.
module smt_dp import smt_pkg::*; #(
  parameter int DEPTH   = 64,
  parameter int ID_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_op_t    op,
  output dp_stat_t  stat,
  output out_item_t result_r
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = ((CNT_W > 7) ? CNT_W : 7) + 1;
  localparam int IDX_W  = (CNT_W > 6) ? CNT_W : 6;

  logic [1:0]         req_r, req_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [6:0]         amt_r, amt_nxt;
  logic [5:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic               lo_found_r, lo_found_nxt;
  out_item_t          result_nxt;

  logic [CNT_W-1:0]   amt_c, ptr_m1, up_dst, dn_src, diff_c, k_c, fill_end;
  logic [CNT_W:0]     dn_sum;
  logic               full_c;

  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [ID_BITS-1:0] wr_data, rd_data;

  assign amt_c    = CNT_W'(amt_r);
  assign ptr_m1   = ptr_r - CNT_W'(1);
  assign up_dst   = ptr_m1 + amt_c;
  assign dn_src   = ptr_r + k_r;
  assign diff_c   = ptr_r - lo_r;
  assign fill_end = lo_r + amt_c;
  assign dn_sum   = (CNT_W + 1)'(ptr_r) + (CNT_W + 1)'(k_r);
  assign k_c      = (SUM_W'(amt_r) < SUM_W'(diff_c)) ? amt_c : diff_c;
  assign full_c   = (SUM_W'(count_r) + SUM_W'(amt_r)) > SUM_W'(DEPTH);

  always_comb begin
    stat.req       = req_r;
    stat.full      = full_c;
    stat.amt_zero  = (amt_r == 7'd0);
    stat.idx_ok    = IDX_W'(idx_r) < IDX_W'(count_r);
    stat.at_end    = (ptr_r == count_r);
    stat.go        = (rd_data <= id_r);
    stat.found     = lo_found_r;
    stat.up_done   = (ptr_r == lo_r);
    stat.fill_done = (ptr_r == fill_end);
    stat.dn_done   = (k_r == '0) || (dn_sum >= (CNT_W + 1)'(count_r));
  end

  always_comb begin
    req_nxt      = req_r;
    id_nxt       = id_r;
    amt_nxt      = amt_r;
    idx_nxt      = idx_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    lo_nxt       = lo_r;
    k_nxt        = k_r;
    lo_found_nxt = lo_found_r;
    result_nxt   = result_r;
    wr_en        = 1'b0;
    wr_addr      = ptr_r[ADDR_W-1:0];
    wr_data      = id_r;
    rd_en        = 1'b0;
    rd_addr      = ptr_r[ADDR_W-1:0];
    case (op)
      OP_LOAD: begin
        req_nxt      = in_data.req_type;
        id_nxt       = ID_BITS'(in_data.item_id);
        amt_nxt      = in_data.amount;
        idx_nxt      = in_data.index;
        ptr_nxt      = '0;
        lo_found_nxt = 1'b0;
      end
      OP_SCAN_RD: begin
        rd_en = 1'b1;
      end
      OP_SCAN_CMP: begin
        if (rd_data <= id_r) begin
          ptr_nxt = ptr_r + CNT_W'(1);
          if (req_r == REQ_REMOVE && rd_data == id_r && !lo_found_r) begin
            lo_found_nxt = 1'b1;
            lo_nxt       = ptr_r;
          end
        end
      end
      OP_SCAN_END: begin
        if (req_r == REQ_ADD) begin
          lo_nxt  = ptr_r;
          ptr_nxt = count_r;
        end else begin
          k_nxt   = k_c;
          ptr_nxt = lo_r;
        end
      end
      OP_UP_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr_m1[ADDR_W-1:0];
      end
      OP_UP_WR: begin
        wr_en   = 1'b1;
        wr_addr = up_dst[ADDR_W-1:0];
        wr_data = rd_data;
        ptr_nxt = ptr_m1;
      end
      OP_FILL: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_r + CNT_W'(1);
      end
      OP_DN_RD: begin
        rd_en   = 1'b1;
        rd_addr = dn_src[ADDR_W-1:0];
      end
      OP_DN_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
        ptr_nxt = ptr_r + CNT_W'(1);
      end
      OP_READ_RD: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(idx_r);
      end
      OP_RESULT: begin
        result_nxt.status     = STS_OK;
        result_nxt.changed    = 7'd0;
        result_nxt.read_value = 16'd0;
        case (req_r)
          REQ_ADD: begin
            if (full_c) begin
              result_nxt.status = STS_FULL;
            end else begin
              count_nxt          = count_r + amt_c;
              result_nxt.changed = amt_r;
            end
          end
          REQ_REMOVE: begin
            if (!lo_found_r) begin
              result_nxt.status = STS_NOT_FOUND;
            end else begin
              count_nxt          = count_r - k_r;
              result_nxt.changed = 7'(k_r);
            end
          end
          REQ_READ: begin
            if (IDX_W'(idx_r) < IDX_W'(count_r)) begin
              result_nxt.read_value = 16'(rd_data);
            end else begin
              result_nxt.status = STS_BAD_INDEX;
            end
          end
          default: begin
          end
        endcase
        result_nxt.entry_count = 7'(count_nxt);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    id_r       <= id_nxt;
    amt_r      <= amt_nxt;
    idx_r      <= idx_nxt;
    ptr_r      <= ptr_nxt;
    lo_r       <= lo_nxt;
    k_r        <= k_nxt;
    lo_found_r <= lo_found_nxt;
    result_r   <= result_nxt;
  end

  smt_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("held count above capacity");

endmodule

@@ src/smt_ctrl.sv @@
// Controller state machine of the sorted multiset table.
// Depends on smt_pkg; issues operation codes to smt_dp and owns the handshakes.
module smt_ctrl import smt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_DECODE   = 12'b0000_0000_0010,
    ST_SCAN_RD  = 12'b0000_0000_0100,
    ST_SCAN_CMP = 12'b0000_0000_1000,
    ST_SCAN_END = 12'b0000_0001_0000,
    ST_UP_RD    = 12'b0000_0010_0000,
    ST_UP_WR    = 12'b0000_0100_0000,
    ST_FILL     = 12'b0000_1000_0000,
    ST_DN_RD    = 12'b0001_0000_0000,
    ST_DN_WR    = 12'b0010_0000_0000,
    ST_READ_RD  = 12'b0100_0000_0000,
    ST_FIN      = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op            = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.req)
          REQ_ADD:    state_nxt = (stat.full || stat.amt_zero) ? ST_FIN : ST_SCAN_RD;
          REQ_REMOVE: state_nxt = ST_SCAN_RD;
          REQ_READ:   state_nxt = stat.idx_ok ? ST_READ_RD : ST_FIN;
          default:    state_nxt = ST_FIN;
        endcase
      end
      ST_SCAN_RD: begin
        if (stat.at_end) begin
          state_nxt = ST_SCAN_END;
        end else begin
          op        = OP_SCAN_RD;
          state_nxt = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        op        = OP_SCAN_CMP;
        state_nxt = stat.go ? ST_SCAN_RD : ST_SCAN_END;
      end
      ST_SCAN_END: begin
        op = OP_SCAN_END;
        if (stat.req == REQ_ADD) begin
          state_nxt = ST_UP_RD;
        end else begin
          state_nxt = stat.found ? ST_DN_RD : ST_FIN;
        end
      end
      ST_UP_RD: begin
        if (stat.up_done) begin
          state_nxt = ST_FILL;
        end else begin
          op        = OP_UP_RD;
          state_nxt = ST_UP_WR;
        end
      end
      ST_UP_WR: begin
        op        = OP_UP_WR;
        state_nxt = ST_UP_RD;
      end
      ST_FILL: begin
        if (stat.fill_done) begin
          state_nxt = ST_FIN;
        end else begin
          op = OP_FILL;
        end
      end
      ST_DN_RD: begin
        if (stat.dn_done) begin
          state_nxt = ST_FIN;
        end else begin
          op        = OP_DN_RD;
          state_nxt = ST_DN_WR;
        end
      end
      ST_DN_WR: begin
        op        = OP_DN_WR;
        state_nxt = ST_DN_RD;
      end
      ST_READ_RD: begin
        op        = OP_READ_RD;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          op            = OP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction taken while busy");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && (!out_valid_r || out_ready) |=> out_valid_r && in_ready)
    else $error("finished transaction not presented");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && out_valid_r && !out_ready |=> state_r == ST_FIN)
    else $error("result overwritten while stalled");

endmodule

@@ src/sorted_multiset_table_core.sv @@
// Sorted multiset table: up to DEPTH identifiers held in ascending order in one RAM.
// Adds and removes scan from the start with a read/compare loop; an add then shifts larger
// entries up and fills the gap, a remove moves later entries down over the removed copies.
// A read of a valid index is a single RAM read; a rejected add or read goes to the result.
// One transaction in flight; the next is accepted the cycle after the result is registered.
// Reset (synchronous, rst_n low) clears the count and handshakes; table RAM is not cleared.
module sorted_multiset_table_core import smt_pkg::*; #(
  parameter int DEPTH   = 64,
  parameter int ID_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_op_t   op;
  dp_stat_t stat;

  smt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .op        (op)
  );

  smt_dp #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .op       (op),
    .stat     (stat),
    .result_r (out_data)
  );

endmodule
